// ===== rtl/core/pbt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbt_pkg: shared types and constants of the participant bitrate table
// Field widths, operation and status codes, controller states and the
// command and status structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package pbt_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int FUNC_W        = 2;
    localparam int ID_W          = 32;
    localparam int RATE_W        = 32;
    localparam int STATUS_W      = 2;
    localparam int OCC_W         = 5;
    localparam int CFG_W         = 5;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD      = 2'd0,
        FUNC_REMOVE   = 2'd1,
        FUNC_ESTIMATE = 2'd2,
        FUNC_QUERY    = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_DUP       = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SCAN_FIND = 2'd0,
        SCAN_MIN  = 2'd1,
        SCAN_WRT  = 2'd2
    } scan_mode_t;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_FIND   = 3'd1,
        S_DECIDE = 3'd2,
        S_MIN    = 3'd3,
        S_WRT    = 3'd4,
        S_RDT    = 3'd5,
        S_RDW    = 3'd6,
        S_OUT    = 3'd7
    } state_t;

    typedef struct packed {
        logic       load;
        logic       start;
        logic       clr_min;
        scan_mode_t mode;
        logic       set_status;
        status_t    status;
        logic       add_commit;
        logic       remove_commit;
        logic       est_write;
        logic       cap_target;
        logic       emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic  found;
        logic  full;
        logic  done;
        logic  out_free;
        func_t func;
    } dp_status_t;

endpackage

// ===== rtl/core/pbt_channels.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbt channels: valid/ready interfaces of the participant bitrate table
// One interface carries operation items in, the other carries result items.
// ----------------------------------------------------------------------------
interface pbt_op_if;
    logic                         valid;
    logic                         ready;
    logic [pbt_pkg::FUNC_W-1:0]   func;
    logic [pbt_pkg::ID_W-1:0]     participant_id;
    logic [pbt_pkg::RATE_W-1:0]   bitrate;

    modport source (output valid, output func, output participant_id, output bitrate,
                    input ready);
    modport sink (input valid, input func, input participant_id, input bitrate,
                  output ready);
endinterface

interface pbt_result_if;
    logic                         valid;
    logic                         ready;
    logic [pbt_pkg::STATUS_W-1:0] status;
    logic [pbt_pkg::RATE_W-1:0]   target_bitrate;
    logic [pbt_pkg::OCC_W-1:0]    occupancy;

    modport source (output valid, output status, output target_bitrate, output occupancy,
                    input ready);
    modport sink (input valid, input status, input target_bitrate, input occupancy,
                  output ready);
endinterface

// ===== rtl/core/pbt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pbt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/pbt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbt_ctrl: sequencer of the participant bitrate table
// Steps each item through lookup, decision, recompute passes and output.
// ----------------------------------------------------------------------------
module pbt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                op_valid,
    output logic                op_ready,
    input  pbt_pkg::dp_status_t st,
    output pbt_pkg::ctrl_cmd_t  cmd
);

    pbt_pkg::state_t state_reg;
    pbt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pbt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_ready   = 1'b0;
        cmd        = '0;
        cmd.mode   = pbt_pkg::SCAN_FIND;
        cmd.status = pbt_pkg::STATUS_OK;
        unique case (state_reg)
            pbt_pkg::S_IDLE:
            begin
                op_ready = 1'b1;
                if (op_valid)
                begin
                    cmd.load   = 1'b1;
                    cmd.start  = 1'b1;
                    state_next = pbt_pkg::S_FIND;
                end
            end
            pbt_pkg::S_FIND:
            begin
                cmd.mode = pbt_pkg::SCAN_FIND;
                if (st.done)
                begin
                    state_next = pbt_pkg::S_DECIDE;
                end
            end
            pbt_pkg::S_DECIDE:
            begin
                unique case (st.func)
                    pbt_pkg::FUNC_ADD:
                    begin
                        if (st.found)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = pbt_pkg::STATUS_DUP;
                            state_next     = pbt_pkg::S_RDT;
                        end
                        else if (st.full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = pbt_pkg::STATUS_FULL;
                            state_next     = pbt_pkg::S_OUT;
                        end
                        else
                        begin
                            cmd.add_commit = 1'b1;
                            state_next     = pbt_pkg::S_OUT;
                        end
                    end
                    pbt_pkg::FUNC_REMOVE,
                    pbt_pkg::FUNC_ESTIMATE:
                    begin
                        if (!st.found)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = pbt_pkg::STATUS_NOT_FOUND;
                            state_next     = pbt_pkg::S_OUT;
                        end
                        else
                        begin
                            cmd.remove_commit = (st.func == pbt_pkg::FUNC_REMOVE);
                            cmd.est_write     = (st.func == pbt_pkg::FUNC_ESTIMATE);
                            cmd.start         = 1'b1;
                            cmd.clr_min       = 1'b1;
                            state_next        = pbt_pkg::S_MIN;
                        end
                    end
                    pbt_pkg::FUNC_QUERY:
                    begin
                        if (!st.found)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = pbt_pkg::STATUS_NOT_FOUND;
                            state_next     = pbt_pkg::S_OUT;
                        end
                        else
                        begin
                            state_next = pbt_pkg::S_RDT;
                        end
                    end
                    default:
                    begin
                        state_next = pbt_pkg::S_OUT;
                    end
                endcase
            end
            pbt_pkg::S_MIN:
            begin
                cmd.mode = pbt_pkg::SCAN_MIN;
                if (st.done)
                begin
                    cmd.start  = 1'b1;
                    state_next = pbt_pkg::S_WRT;
                end
            end
            pbt_pkg::S_WRT:
            begin
                cmd.mode = pbt_pkg::SCAN_WRT;
                if (st.done)
                begin
                    state_next = (st.func == pbt_pkg::FUNC_ESTIMATE) ? pbt_pkg::S_RDT
                                                                     : pbt_pkg::S_OUT;
                end
            end
            pbt_pkg::S_RDT:
            begin
                state_next = pbt_pkg::S_RDW;
            end
            pbt_pkg::S_RDW:
            begin
                cmd.cap_target = 1'b1;
                state_next     = pbt_pkg::S_OUT;
            end
            pbt_pkg::S_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = pbt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pbt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/pbt_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbt_dp: datapath of the participant bitrate table
// Slot memories, valid bits, slot scanner, minimum tracker and result register.
// ----------------------------------------------------------------------------
module pbt_dp #(
    parameter int SLOTS = pbt_pkg::SLOTS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [pbt_pkg::CFG_W-1:0]    cfg_data,
    input  logic [pbt_pkg::FUNC_W-1:0]   op_func,
    input  logic [pbt_pkg::ID_W-1:0]     op_id,
    input  logic [pbt_pkg::RATE_W-1:0]   op_bitrate,
    input  pbt_pkg::ctrl_cmd_t           cmd,
    output pbt_pkg::dp_status_t          st,
    input  logic                         res_ready,
    output logic                         res_valid,
    output logic [pbt_pkg::STATUS_W-1:0] res_status,
    output logic [pbt_pkg::RATE_W-1:0]   res_target,
    output logic [pbt_pkg::OCC_W-1:0]    res_occupancy
);

    localparam int IDXW = $clog2(SLOTS);
    localparam int OCCW = $clog2(SLOTS + 1);
    localparam int LIMW = (OCCW > pbt_pkg::CFG_W) ? OCCW : pbt_pkg::CFG_W;
    localparam logic [IDXW-1:0] LAST_IDX  = IDXW'(SLOTS - 1);
    localparam logic [LIMW-1:0] SLOTS_LIM = LIMW'(SLOTS);
    localparam int RW = pbt_pkg::RATE_W;

    // Control state.
    logic [SLOTS-1:0]         valid_reg,        valid_next;
    logic [OCCW-1:0]          occ_reg,          occ_next;
    logic [pbt_pkg::CFG_W-1:0] max_reg,         max_next;
    logic                     issue_active_reg, issue_active_next;
    logic                     rd_live_reg,      rd_live_next;
    logic                     rd_last_reg,      rd_last_next;
    logic                     found_reg,        found_next;
    logic                     free_found_reg,   free_found_next;
    logic                     res_valid_reg,    res_valid_next;

    // Payload state.
    pbt_pkg::func_t           func_reg,         func_next;
    logic [pbt_pkg::ID_W-1:0] id_reg,           id_next;
    logic [RW-1:0]            rate_reg,         rate_next;
    logic [IDXW-1:0]          idx_reg,          idx_next;
    logic [IDXW-1:0]          rd_idx_reg,       rd_idx_next;
    logic [IDXW-1:0]          at_reg,           at_next;
    logic [IDXW-1:0]          free_reg,         free_next;
    logic [RW-1:0]            min1_reg,         min1_next;
    logic                     min1_seen_reg,    min1_seen_next;
    logic [IDXW-1:0]          min1_idx_reg,     min1_idx_next;
    logic [RW-1:0]            min2_reg,         min2_next;
    logic                     min2_seen_reg,    min2_seen_next;
    pbt_pkg::status_t         status_reg,       status_next;
    logic [RW-1:0]            target_reg,       target_next;
    pbt_pkg::status_t         res_status_reg,   res_status_next;
    logic [RW-1:0]            res_target_reg,   res_target_next;
    logic [pbt_pkg::OCC_W-1:0] res_occ_reg,     res_occ_next;

    // Memory ports.
    logic                     ident_we;
    logic [pbt_pkg::ID_W-1:0] ident_rdata;
    logic                     est_we;
    logic [IDXW-1:0]          est_waddr;
    logic [RW-1:0]            est_wdata;
    logic [RW-1:0]            est_rdata;
    logic                     tgt_we;
    logic [IDXW-1:0]          tgt_waddr;
    logic [RW-1:0]            tgt_wdata;
    logic [RW-1:0]            tgt_rdata;

    logic [LIMW-1:0]          max_ext;
    logic [LIMW-1:0]          limit;
    logic [RW-1:0]            wrt_value;

    pbt_ram #(.WIDTH(pbt_pkg::ID_W), .DEPTH(SLOTS)) u_ident_ram (
        .clk   (clk),
        .we    (ident_we),
        .waddr (free_reg),
        .wdata (id_reg),
        .raddr (idx_reg),
        .rdata (ident_rdata)
    );

    pbt_ram #(.WIDTH(RW), .DEPTH(SLOTS)) u_est_ram (
        .clk   (clk),
        .we    (est_we),
        .waddr (est_waddr),
        .wdata (est_wdata),
        .raddr (idx_reg),
        .rdata (est_rdata)
    );

    pbt_ram #(.WIDTH(RW), .DEPTH(SLOTS)) u_tgt_ram (
        .clk   (clk),
        .we    (tgt_we),
        .waddr (tgt_waddr),
        .wdata (tgt_wdata),
        .raddr (at_reg),
        .rdata (tgt_rdata)
    );

    always_comb
    begin
        max_ext = LIMW'(max_reg);
        limit   = (max_ext < SLOTS_LIM) ? max_ext : SLOTS_LIM;
    end

    // A slot's target excludes its own estimate, so the holder of the lowest
    // estimate gets the second lowest one.
    always_comb
    begin
        if (!min1_seen_reg)
        begin
            wrt_value = '0;
        end
        else if (rd_idx_reg == min1_idx_reg)
        begin
            wrt_value = min2_seen_reg ? min2_reg : '0;
        end
        else
        begin
            wrt_value = min1_reg;
        end
    end

    always_comb
    begin
        ident_we  = cmd.add_commit;
        est_we    = 1'b0;
        est_waddr = free_reg;
        est_wdata = '0;
        tgt_we    = 1'b0;
        tgt_waddr = free_reg;
        tgt_wdata = '0;
        if (cmd.add_commit)
        begin
            est_we = 1'b1;
            tgt_we = 1'b1;
        end
        else if (cmd.est_write)
        begin
            est_we    = 1'b1;
            est_waddr = at_reg;
            est_wdata = rate_reg;
        end
        if (rd_live_reg && cmd.mode == pbt_pkg::SCAN_WRT)
        begin
            tgt_we    = 1'b1;
            tgt_waddr = rd_idx_reg;
            tgt_wdata = wrt_value;
        end
    end

    always_comb
    begin
        valid_next        = valid_reg;
        occ_next          = occ_reg;
        max_next          = max_reg;
        issue_active_next = issue_active_reg;
        found_next        = found_reg;
        free_found_next   = free_found_reg;
        res_valid_next    = res_valid_reg;
        func_next         = func_reg;
        id_next           = id_reg;
        rate_next         = rate_reg;
        idx_next          = idx_reg;
        at_next           = at_reg;
        free_next         = free_reg;
        min1_next         = min1_reg;
        min1_seen_next    = min1_seen_reg;
        min1_idx_next     = min1_idx_reg;
        min2_next         = min2_reg;
        min2_seen_next    = min2_seen_reg;
        status_next       = status_reg;
        target_next       = target_reg;
        res_status_next   = res_status_reg;
        res_target_next   = res_target_reg;
        res_occ_next      = res_occ_reg;

        if (cfg_we)
        begin
            max_next = cfg_data;
        end

        if (cmd.load)
        begin
            func_next       = pbt_pkg::func_t'(op_func);
            id_next         = op_id;
            rate_next       = op_bitrate;
            found_next      = 1'b0;
            free_found_next = 1'b0;
            status_next     = pbt_pkg::STATUS_OK;
            target_next     = '0;
        end

        // Address issue stage of the slot scanner.
        if (cmd.start)
        begin
            idx_next          = '0;
            issue_active_next = 1'b1;
        end
        else if (issue_active_reg)
        begin
            idx_next = idx_reg + IDXW'(1);
            if (idx_reg == LAST_IDX)
            begin
                idx_next          = idx_reg;
                issue_active_next = 1'b0;
            end
        end
        rd_live_next = issue_active_reg;
        rd_last_next = issue_active_reg && (idx_reg == LAST_IDX);
        rd_idx_next  = idx_reg;

        // Read data stage of the slot scanner.
        if (rd_live_reg)
        begin
            if (cmd.mode == pbt_pkg::SCAN_FIND)
            begin
                if (valid_reg[rd_idx_reg] && ident_rdata == id_reg && !found_reg)
                begin
                    found_next = 1'b1;
                    at_next    = rd_idx_reg;
                end
                if (!valid_reg[rd_idx_reg] && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_next       = rd_idx_reg;
                end
            end
            else if (cmd.mode == pbt_pkg::SCAN_MIN)
            begin
                if (valid_reg[rd_idx_reg] && est_rdata != '0)
                begin
                    if (!min1_seen_reg || est_rdata < min1_reg)
                    begin
                        min2_next      = min1_reg;
                        min2_seen_next = min1_seen_reg;
                        min1_next      = est_rdata;
                        min1_idx_next  = rd_idx_reg;
                        min1_seen_next = 1'b1;
                    end
                    else if (!min2_seen_reg || est_rdata < min2_reg)
                    begin
                        min2_next      = est_rdata;
                        min2_seen_next = 1'b1;
                    end
                end
            end
        end

        if (cmd.clr_min)
        begin
            min1_seen_next = 1'b0;
            min2_seen_next = 1'b0;
        end

        if (cmd.set_status)
        begin
            status_next = cmd.status;
        end

        if (cmd.add_commit)
        begin
            valid_next[free_reg] = 1'b1;
            occ_next             = occ_reg + OCCW'(1);
        end
        else if (cmd.remove_commit)
        begin
            valid_next[at_reg] = 1'b0;
            occ_next           = occ_reg - OCCW'(1);
        end

        if (cmd.cap_target)
        begin
            target_next = tgt_rdata;
        end

        if (cmd.emit)
        begin
            res_valid_next  = 1'b1;
            res_status_next = status_reg;
            res_target_next = target_reg;
            res_occ_next    = pbt_pkg::OCC_W'(occ_reg);
        end
        else if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= '0;
            occ_reg          <= '0;
            max_reg          <= pbt_pkg::CFG_RESET;
            issue_active_reg <= 1'b0;
            rd_live_reg      <= 1'b0;
            rd_last_reg      <= 1'b0;
            found_reg        <= 1'b0;
            free_found_reg   <= 1'b0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            valid_reg        <= valid_next;
            occ_reg          <= occ_next;
            max_reg          <= max_next;
            issue_active_reg <= issue_active_next;
            rd_live_reg      <= rd_live_next;
            rd_last_reg      <= rd_last_next;
            found_reg        <= found_next;
            free_found_reg   <= free_found_next;
            res_valid_reg    <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        id_reg         <= id_next;
        rate_reg       <= rate_next;
        idx_reg        <= idx_next;
        rd_idx_reg     <= rd_idx_next;
        at_reg         <= at_next;
        free_reg       <= free_next;
        min1_reg       <= min1_next;
        min1_seen_reg  <= min1_seen_next;
        min1_idx_reg   <= min1_idx_next;
        min2_reg       <= min2_next;
        min2_seen_reg  <= min2_seen_next;
        status_reg     <= status_next;
        target_reg     <= target_next;
        res_status_reg <= res_status_next;
        res_target_reg <= res_target_next;
        res_occ_reg    <= res_occ_next;
    end

    always_comb
    begin
        st.found    = found_reg;
        st.full     = (LIMW'(occ_reg) >= limit);
        st.done     = rd_live_reg && rd_last_reg;
        st.out_free = !res_valid_reg || res_ready;
        st.func     = func_reg;
    end

    assign res_valid     = res_valid_reg;
    assign res_status    = res_status_reg;
    assign res_target    = res_target_reg;
    assign res_occupancy = res_occ_reg;

endmodule

// ===== rtl/core/participant_bitrate_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// participant_bitrate_table: room participant table with target bitrates
// Adds, removes, estimate reports and target queries on up to SLOTS slots.
// ----------------------------------------------------------------------------
// Each item on op is one operation and produces exactly one result item on
// result. The block handles one item at a time. Every item first scans all
// slots of the identifier memory to find the addressed participant and the
// lowest free slot. An add, a query or any refused operation then goes to
// the output, after a read of the participant's target where it has to be
// read (a query that finds its participant or a duplicate add). A successful
// remove or estimate report adds two further passes over the slots, one
// through the estimate memory to find the lowest and second lowest nonzero
// estimates and one that writes every slot's target; an estimate report then
// also reads back its target. A result register sits on the output, so the
// next item is accepted while the last result waits.
// The room limit register is written through cfg_we and cfg_data; the user
// must write it only while the block is idle, which the block itself does
// not enforce. The limit in force is the smaller of it and SLOTS.
// ----------------------------------------------------------------------------
module participant_bitrate_table #(
    parameter int SLOTS = pbt_pkg::SLOTS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [pbt_pkg::CFG_W-1:0] cfg_data,
    pbt_op_if.sink                    op,
    pbt_result_if.source              result
);

    // Command and status bundles between the sequencer and the datapath.
    pbt_pkg::ctrl_cmd_t  cmd;
    pbt_pkg::dp_status_t st;

    logic                         op_ready;
    logic                         res_valid;
    logic [pbt_pkg::STATUS_W-1:0] res_status;
    logic [pbt_pkg::RATE_W-1:0]   res_target;
    logic [pbt_pkg::OCC_W-1:0]    res_occupancy;

    // The sequencer walks each item through lookup, decision, the optional
    // recompute passes, the target read and the hand-off to the result register.
    pbt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op.valid),
        .op_ready (op_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // The datapath holds the slot memories, the valid bits, the occupancy
    // count, the room limit and the result register.
    pbt_dp #(.SLOTS(SLOTS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .op_func       (op.func),
        .op_id         (op.participant_id),
        .op_bitrate    (op.bitrate),
        .cmd           (cmd),
        .st            (st),
        .res_ready     (result.ready),
        .res_valid     (res_valid),
        .res_status    (res_status),
        .res_target    (res_target),
        .res_occupancy (res_occupancy)
    );

    assign op.ready              = op_ready;
    assign result.valid          = res_valid;
    assign result.status         = res_status;
    assign result.target_bitrate = res_target;
    assign result.occupancy      = res_occupancy;

    // An accepted item keeps the sequencer busy, so no second item is taken
    // in the following cycle.
    a_one_item_at_a_time: assert property (
        @(posedge clk) disable iff (!rst_n)
        (op.valid && op.ready) |=> !op.ready
    ) else $error("second item accepted while one was in progress");

    // At most one table update is issued in any cycle.
    a_single_update: assert property (
        @(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.add_commit, cmd.remove_commit, cmd.est_write})
    ) else $error("conflicting table updates in one cycle");

    // A finished item always shows up on the result channel in the next cycle.
    a_emit_visible: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.emit |=> result.valid
    ) else $error("finished item did not reach the result register");

    // Handing a result over only happens when the result register is free.
    a_emit_when_free: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!result.valid || result.ready)
    ) else $error("result overwritten before it was taken");

endmodule

// ===== sim/tb_participant_bitrate_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_participant_bitrate_table: self-checking bench for the bitrate table
// Drives add, remove, estimate and query items through the op channel and
// predicts every result item with a software copy of the participant room.
// A directed opening covers the corner cases. Random traffic follows under
// several room limits, with random idling on both sides, a long receiver
// hold-off and a full drain in the middle of the run.
// ----------------------------------------------------------------------------
module tb_participant_bitrate_table;

    localparam int SLOTS      = pbt_pkg::SLOTS_DEFAULT;
    localparam int POOL_SIZE  = 24;
    localparam int STALL_MAX  = 4000;
    localparam int END_WAIT   = 80;
    localparam int HOLD_LONG  = 300;

    // One expected result item, laid out like the result channel.
    typedef struct packed {
        pbt_pkg::status_t           status;
        logic [pbt_pkg::RATE_W-1:0] target_bitrate;
        logic [pbt_pkg::OCC_W-1:0]  occupancy;
    } op_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [pbt_pkg::CFG_W-1:0] cfg_data;

    pbt_op_if     op_ch();
    pbt_result_if res_ch();

    participant_bitrate_table #(
        .SLOTS (SLOTS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .op       (op_ch),
        .result   (res_ch)
    );

    // 20 ns clock period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Software copy of the room: one entry per slot, plus the limit register.
    logic                       room_present  [SLOTS];
    logic [pbt_pkg::ID_W-1:0]   room_ident    [SLOTS];
    logic [pbt_pkg::RATE_W-1:0] room_estimate [SLOTS];
    logic [pbt_pkg::RATE_W-1:0] room_target   [SLOTS];
    logic [pbt_pkg::CFG_W-1:0]  room_limit;

    // Results that the room owes, oldest first.
    op_result_t         awaited_results [$];

    // Identifiers that the random traffic draws from. The pool is larger than
    // the room, so adds run into a full room and lookups both hit and miss.
    logic [pbt_pkg::ID_W-1:0] id_pool [POOL_SIZE];

    // Idle percentages of each side and the receiver hold-off request.
    int                 tx_idle_pct = 19;
    int                 rx_idle_pct = 19;
    int                 rx_hold_req = 0;

    int                 error_count = 0;
    int                 op_tally     [4];
    int                 status_tally [4];
    int                 limit_writes = 0;

    // Every present participant's target becomes the lowest nonzero estimate
    // among the other present participants; zero when none has reported.
    function automatic void room_retarget();
        logic [pbt_pkg::RATE_W-1:0] lowest;
        logic                       seen;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (room_present[s])
            begin
                lowest = '1;
                seen   = 1'b0;
                for (int r = 0; r < SLOTS; r++)
                begin
                    if (r != s && room_present[r] && room_estimate[r] != '0)
                    begin
                        seen = 1'b1;
                        if (room_estimate[r] < lowest)
                            lowest = room_estimate[r];
                    end
                end
                room_target[s] = seen ? lowest : '0;
            end
        end
    endfunction

    // Applies one operation to the room copy and returns the result it owes.
    function automatic op_result_t room_apply_op(input pbt_pkg::func_t f,
                                                 input logic [pbt_pkg::ID_W-1:0] id,
                                                 input logic [pbt_pkg::RATE_W-1:0] rate);
        op_result_t outcome;
        int         at;
        int         count;
        int         lim;
        logic       placed;
        at     = -1;
        count  = 0;
        placed = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (room_present[i])
            begin
                count++;
                if (room_ident[i] == id && at < 0)
                    at = i;
            end
        end
        // A limit register above the slot count is clamped to the slot count.
        lim = (room_limit < SLOTS) ? int'(room_limit) : SLOTS;
        outcome.status         = pbt_pkg::STATUS_OK;
        outcome.target_bitrate = '0;
        case (f)
            pbt_pkg::FUNC_ADD:
            begin
                if (at >= 0)
                begin
                    outcome.status         = pbt_pkg::STATUS_DUP;
                    outcome.target_bitrate = room_target[at];
                end
                else if (count >= lim)
                begin
                    outcome.status = pbt_pkg::STATUS_FULL;
                end
                else
                begin
                    // The lowest free slot is taken; no recompute on add.
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!room_present[i] && !placed)
                        begin
                            placed           = 1'b1;
                            room_present[i]  = 1'b1;
                            room_ident[i]    = id;
                            room_estimate[i] = '0;
                            room_target[i]   = '0;
                        end
                    end
                    count++;
                end
            end
            pbt_pkg::FUNC_REMOVE:
            begin
                if (at < 0)
                begin
                    outcome.status = pbt_pkg::STATUS_NOT_FOUND;
                end
                else
                begin
                    room_present[at] = 1'b0;
                    count--;
                    room_retarget();
                end
            end
            pbt_pkg::FUNC_ESTIMATE:
            begin
                if (at < 0)
                begin
                    outcome.status = pbt_pkg::STATUS_NOT_FOUND;
                end
                else
                begin
                    room_estimate[at] = rate;
                    room_retarget();
                    outcome.target_bitrate = room_target[at];
                end
            end
            default:
            begin
                if (at < 0)
                    outcome.status = pbt_pkg::STATUS_NOT_FOUND;
                else
                    outcome.target_bitrate = room_target[at];
            end
        endcase
        outcome.occupancy = count[pbt_pkg::OCC_W-1:0];
        return outcome;
    endfunction

    // Offers one item, possibly after a random gap, and records what the room
    // owes for it at the edge where it is accepted. Valid stays high after
    // acceptance so that back-to-back items never drop it for a cycle.
    task automatic issue_op(input pbt_pkg::func_t f, input logic [pbt_pkg::ID_W-1:0] id,
                            input logic [pbt_pkg::RATE_W-1:0] rate);
        op_result_t predicted;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            op_ch.valid <= 1'b0;
            @(posedge clk);
        end
        op_ch.valid          <= 1'b1;
        op_ch.func           <= f;
        op_ch.participant_id <= id;
        op_ch.bitrate        <= rate;
        do
            @(posedge clk);
        while (!op_ch.ready);
        predicted = room_apply_op(f, id, rate);
        awaited_results = {awaited_results, predicted};
        op_tally[f]++;
        status_tally[predicted.status]++;
    endtask

    // The sender stops offering and waits until every owed result has come.
    task automatic await_all_results();
        op_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_results.size() != 0);
    endtask

    // Writes the room limit; only called while nothing is in flight.
    task automatic write_room_limit(input logic [pbt_pkg::CFG_W-1:0] value);
        cfg_data <= value;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we     <= 1'b0;
        room_limit = value;
        limit_writes++;
    endtask

    // Random traffic. The percentages pick the operation; what is left over
    // goes to queries. A few lookups use fresh identifiers that miss.
    task automatic send_mixed_ops(input int count, input int add_pct,
                                  input int remove_pct, input int est_pct);
        int                         pick;
        pbt_pkg::func_t             f;
        logic [pbt_pkg::ID_W-1:0]   id;
        logic [pbt_pkg::RATE_W-1:0] rate;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            if (pick < add_pct)
                f = pbt_pkg::FUNC_ADD;
            else if (pick < add_pct + remove_pct)
                f = pbt_pkg::FUNC_REMOVE;
            else if (pick < add_pct + remove_pct + est_pct)
                f = pbt_pkg::FUNC_ESTIMATE;
            else
                f = pbt_pkg::FUNC_QUERY;
            if (f != pbt_pkg::FUNC_ADD && $urandom_range(99) < 8)
                id = $urandom;
            else
                id = id_pool[$urandom_range(POOL_SIZE - 1)];
            // Zero and all-ones estimates are common, and small values make
            // the minimum move between participants often.
            pick = $urandom_range(99);
            if (pick < 10)
                rate = '0;
            else if (pick < 20)
                rate = '1;
            else if (pick < 45)
                rate = $urandom_range(1000, 1);
            else
                rate = $urandom;
            issue_op(f, id, rate);
        end
    endtask

    // Corner cases on an empty room: misses, extreme identifiers, duplicate
    // adds, zero and all-ones estimates, and the recompute after a remove.
    task automatic test_basic_operations();
        issue_op(pbt_pkg::FUNC_QUERY,    32'h0000_0000, 32'd0);
        issue_op(pbt_pkg::FUNC_REMOVE,   32'h0000_0005, 32'd0);
        issue_op(pbt_pkg::FUNC_ESTIMATE, 32'h0000_0007, 32'd100);
        issue_op(pbt_pkg::FUNC_ADD,      32'h0000_0000, 32'd0);
        issue_op(pbt_pkg::FUNC_ADD,      32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue_op(pbt_pkg::FUNC_ADD,      32'h0000_0000, 32'd0);
        issue_op(pbt_pkg::FUNC_ESTIMATE, 32'h0000_0000, 32'hFFFF_FFFF);
        // An estimate of zero is stored but counts as not reported.
        issue_op(pbt_pkg::FUNC_ESTIMATE, 32'hFFFF_FFFF, 32'd0);
        issue_op(pbt_pkg::FUNC_ADD,      32'h5A5A_A5A5, 32'd0);
        issue_op(pbt_pkg::FUNC_ESTIMATE, 32'h5A5A_A5A5, 32'd1);
        // A duplicate add reports the participant's current target.
        issue_op(pbt_pkg::FUNC_ADD,      32'h0000_0000, 32'd0);
        issue_op(pbt_pkg::FUNC_QUERY,    32'hFFFF_FFFF, 32'd0);
        issue_op(pbt_pkg::FUNC_REMOVE,   32'h0000_0000, 32'd0);
        issue_op(pbt_pkg::FUNC_QUERY,    32'h5A5A_A5A5, 32'd0);
        await_all_results();
    endtask

    // Room limit: a full room, a limit below the occupancy and a limit above
    // the slot count.
    task automatic test_room_limit();
        write_room_limit(5'd3);
        issue_op(pbt_pkg::FUNC_ADD,      32'h1234_5678, 32'd0);
        issue_op(pbt_pkg::FUNC_ADD,      32'h8765_4321, 32'd0);
        await_all_results();
        write_room_limit(5'd0);
        issue_op(pbt_pkg::FUNC_ADD,      32'h8765_4321, 32'd0);
        issue_op(pbt_pkg::FUNC_ESTIMATE, 32'h1234_5678, 32'h8000_0000);
        await_all_results();
        write_room_limit(5'd31);
        issue_op(pbt_pkg::FUNC_ADD,      32'h8765_4321, 32'd0);
        issue_op(pbt_pkg::FUNC_QUERY,    32'h5A5A_A5A5, 32'd0);
        await_all_results();
        write_room_limit(pbt_pkg::CFG_RESET);
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering, so the result register fills and the op channel stalls.
    task automatic test_result_backpressure();
        rx_hold_req = HOLD_LONG;
        send_mixed_ops(12, 30, 15, 35);
        await_all_results();
    endtask

    // The sender pauses in the middle of random traffic until the room has
    // answered everything, then goes on.
    task automatic test_pause_until_drained();
        send_mixed_ops(40, 35, 15, 35);
        await_all_results();
        send_mixed_ops(40, 35, 15, 35);
        await_all_results();
    endtask

    // Random traffic with no idling on either side.
    task automatic test_back_to_back();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_mixed_ops(250, 35, 15, 35);
        await_all_results();
        tx_idle_pct = 19;
        rx_idle_pct = 19;
    endtask

    // Random traffic under a sequence of room limits, the extremes among
    // them. The mix shifts toward adds or removes so occupancy sweeps its
    // range under each limit.
    task automatic test_limit_sweep();
        send_mixed_ops(400, 35, 15, 35);
        await_all_results();
        write_room_limit(5'd5);
        send_mixed_ops(250, 35, 15, 30);
        await_all_results();
        write_room_limit(5'd0);
        send_mixed_ops(100, 30, 10, 40);
        await_all_results();
        write_room_limit(5'd31);
        send_mixed_ops(300, 45, 10, 30);
        await_all_results();
        write_room_limit(5'd1);
        send_mixed_ops(150, 25, 30, 30);
        await_all_results();
        for (int p = 0; p < 3; p++)
        begin
            write_room_limit(pbt_pkg::CFG_W'($urandom_range(31)));
            send_mixed_ops(100, 35, 20, 30);
            await_all_results();
        end
    endtask

    // Result sink: random ready, overridden by a hold-off that this process
    // counts down itself once a request shows up.
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req > 0)
            begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Each accepted result item is compared with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        op_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0d %0d %0d",
                         $time, res_ch.status, res_ch.target_bitrate, res_ch.occupancy);
                error_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (res_ch.status !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, res_ch.status);
                    error_count++;
                end
                if (res_ch.target_bitrate !== want.target_bitrate)
                begin
                    $display("%0t: target_bitrate mismatch, expected %0d, actual %0d",
                             $time, want.target_bitrate, res_ch.target_bitrate);
                    error_count++;
                end
                if (res_ch.occupancy !== want.occupancy)
                begin
                    $display("%0t: occupancy mismatch, expected %0d, actual %0d",
                             $time, want.occupancy, res_ch.occupancy);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when neither channel has moved an item for too
    // long. The longest legitimate quiet stretch is the receiver hold-off.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_MAX)
        begin
            @(posedge clk);
            if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles", $time, STALL_MAX);
        $display("tb: failure");
        $finish;
    end

    initial
    begin : test_sequence
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_data             <= pbt_pkg::CFG_RESET;
        op_ch.valid          <= 1'b0;
        op_ch.func           <= pbt_pkg::FUNC_ADD;
        op_ch.participant_id <= '0;
        op_ch.bitrate        <= '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            room_present[i]  = 1'b0;
            room_ident[i]    = '0;
            room_estimate[i] = '0;
            room_target[i]   = '0;
        end
        for (int i = 0; i < 4; i++)
        begin
            op_tally[i]     = 0;
            status_tally[i] = 0;
        end
        room_limit = pbt_pkg::CFG_RESET;
        id_pool[0] = 32'h0000_0000;
        id_pool[1] = 32'hFFFF_FFFF;
        id_pool[2] = 32'h5A5A_A5A5;
        id_pool[3] = 32'h1234_5678;
        id_pool[4] = 32'h8765_4321;
        for (int i = 5; i < POOL_SIZE; i++)
            id_pool[i] = $urandom;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_operations();
        test_room_limit();
        test_result_backpressure();
        test_back_to_back();
        test_pause_until_drained();
        test_limit_sweep();

        await_all_results();
        repeat (END_WAIT) @(posedge clk);

        $display("covered %0d items: %0d add, %0d remove, %0d estimate, %0d query",
                 op_tally[pbt_pkg::FUNC_ADD] + op_tally[pbt_pkg::FUNC_REMOVE]
                 + op_tally[pbt_pkg::FUNC_ESTIMATE] + op_tally[pbt_pkg::FUNC_QUERY],
                 op_tally[pbt_pkg::FUNC_ADD], op_tally[pbt_pkg::FUNC_REMOVE],
                 op_tally[pbt_pkg::FUNC_ESTIMATE], op_tally[pbt_pkg::FUNC_QUERY]);
        $display("outcomes: %0d ok, %0d duplicate, %0d room full, %0d not found",
                 status_tally[pbt_pkg::STATUS_OK], status_tally[pbt_pkg::STATUS_DUP],
                 status_tally[pbt_pkg::STATUS_FULL], status_tally[pbt_pkg::STATUS_NOT_FOUND]);
        $display("%0d limit writes, %0d mismatches", limit_writes, error_count);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/pbt_pkg.sv
rtl/core/pbt_channels.sv
rtl/core/pbt_ram.sv
rtl/core/pbt_ctrl.sv
rtl/core/pbt_dp.sv
rtl/core/participant_bitrate_table.sv
sim/tb_participant_bitrate_table.sv
